// ===== sv/hsbt_pkg.sv =====
// types and constants shared by the byte transfer block
`timescale 1ns / 1ps
`default_nettype none
package hsbt_pkg;

  localparam logic [1:0] OP_SEND = 2'd1;
  localparam logic [1:0] OP_RECV = 2'd2;

  localparam logic [2:0] BITS_LAST = 3'd7;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_SEND = 2'd1,
    KIND_RECV = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] tx_byte;
    logic       clock_seen;
    logic       data_seen;
  } item_t;

  typedef enum logic [6:0] {
    PH_IDLE         = 7'b0000001,
    PH_TX_CLK_ON    = 7'b0000010,
    PH_TX_CLK_OFF   = 7'b0000100,
    PH_TX_DATA_ON   = 7'b0001000,
    PH_RX_DATA_OFF  = 7'b0010000,
    PH_RX_CLK_CHG   = 7'b0100000,
    PH_RX_DATA_ON   = 7'b1000000
  } phase_t;

endpackage
`default_nettype wire

// ===== sv/hsbt_front.sv =====
// front end: classifies incoming items and pushes them into the queue
`timescale 1ns / 1ps
`default_nettype none
module hsbt_front (
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_op,
  input  wire logic [7:0]    in_tx_byte,
  input  wire logic          in_clock_seen,
  input  wire logic          in_data_seen,
  input  wire logic          q_full,
  output logic               q_push,
  output hsbt_pkg::item_t    q_item
);

  always_comb begin
    case (in_op)
      hsbt_pkg::OP_SEND: q_item.kind = hsbt_pkg::KIND_SEND;
      hsbt_pkg::OP_RECV: q_item.kind = hsbt_pkg::KIND_RECV;
      default:           q_item.kind = hsbt_pkg::KIND_TICK;
    endcase
    q_item.tx_byte    = in_tx_byte;
    q_item.clock_seen = in_clock_seen;
    q_item.data_seen  = in_data_seen;
  end

  assign in_ready = ~q_full;
  assign q_push   = in_valid & ~q_full;

endmodule
`default_nettype wire

// ===== sv/hsbt_queue.sv =====
// two-entry item queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module hsbt_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire hsbt_pkg::item_t push_item,
  output logic                 full,
  input  wire logic            pop,
  output logic                 q_valid,
  output hsbt_pkg::item_t      q_item
);

  hsbt_pkg::item_t ent_r [2];
  logic            wr_ptr_r;
  logic            wr_ptr_nxt;
  logic            rd_ptr_r;
  logic            rd_ptr_nxt;
  logic [1:0]      count_r;
  logic [1:0]      count_nxt;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_item  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== sv/hsbt_back.sv =====
// back end: line handshake state machine and result register
`timescale 1ns / 1ps
`default_nettype none
module hsbt_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire hsbt_pkg::item_t q_item,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_clock_drive,
  output logic                 out_data_drive,
  output logic                 out_busy_res,
  output logic                 out_done_res,
  output logic [7:0]           out_rx_byte,
  output logic                 out_rejected
);

  hsbt_pkg::phase_t phase_r;
  hsbt_pkg::phase_t phase_nxt;
  logic [2:0]       bits_r;
  logic [2:0]       bits_nxt;
  logic [7:0]       shift_r;
  logic [7:0]       shift_nxt;
  logic             sampled_r;
  logic             sampled_nxt;
  logic             receiving_r;
  logic             receiving_nxt;
  logic             clock_out_r;
  logic             clock_out_nxt;
  logic             data_out_r;
  logic             data_out_nxt;
  logic             done;
  logic             rej;

  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             res_clock_r;
  logic             res_data_r;
  logic             res_busy_r;
  logic             res_done_r;
  logic [7:0]       res_rx_r;
  logic             res_rej_r;

  logic             clk_s;
  logic             dat_s;

  assign pop   = q_valid & (~out_valid_r | out_ready);
  assign clk_s = q_item.clock_seen;
  assign dat_s = q_item.data_seen;

  always_comb begin
    phase_nxt     = phase_r;
    bits_nxt      = bits_r;
    shift_nxt     = shift_r;
    sampled_nxt   = sampled_r;
    receiving_nxt = receiving_r;
    clock_out_nxt = clock_out_r;
    data_out_nxt  = data_out_r;
    done          = 1'b0;
    rej           = 1'b0;
    if (q_item.kind != hsbt_pkg::KIND_TICK) begin
      if (phase_r != hsbt_pkg::PH_IDLE) begin
        rej = 1'b1;
      end else if (q_item.kind == hsbt_pkg::KIND_SEND) begin
        receiving_nxt = 1'b0;
        shift_nxt     = q_item.tx_byte;
        bits_nxt      = hsbt_pkg::BITS_LAST;
        data_out_nxt  = q_item.tx_byte[7];
        clock_out_nxt = 1'b0;
        phase_nxt     = hsbt_pkg::PH_TX_CLK_ON;
      end else begin
        receiving_nxt = 1'b1;
        shift_nxt     = 8'd0;
        bits_nxt      = hsbt_pkg::BITS_LAST;
        clock_out_nxt = 1'b0;
        phase_nxt     = hsbt_pkg::PH_RX_DATA_OFF;
      end
    end else begin
      case (phase_r)
        hsbt_pkg::PH_IDLE: begin
        end
        hsbt_pkg::PH_TX_CLK_ON: begin
          if (clk_s) begin
            data_out_nxt = ~shift_r[7];
            phase_nxt    = hsbt_pkg::PH_TX_CLK_OFF;
          end
        end
        hsbt_pkg::PH_TX_CLK_OFF: begin
          if (!clk_s) begin
            data_out_nxt  = 1'b0;
            clock_out_nxt = 1'b1;
            phase_nxt     = hsbt_pkg::PH_TX_DATA_ON;
          end
        end
        hsbt_pkg::PH_TX_DATA_ON: begin
          if (dat_s) begin
            if (bits_r == 3'd0) begin
              phase_nxt = hsbt_pkg::PH_IDLE;
              done      = 1'b1;
            end else begin
              bits_nxt      = bits_r - 3'd1;
              shift_nxt     = {shift_r[6:0], 1'b0};
              data_out_nxt  = shift_r[6];
              clock_out_nxt = 1'b0;
              phase_nxt     = hsbt_pkg::PH_TX_CLK_ON;
            end
          end
        end
        hsbt_pkg::PH_RX_DATA_OFF: begin
          if (!dat_s) begin
            sampled_nxt  = clk_s;
            shift_nxt    = {clk_s, shift_r[7:1]};
            data_out_nxt = 1'b1;
            phase_nxt    = hsbt_pkg::PH_RX_CLK_CHG;
          end
        end
        hsbt_pkg::PH_RX_CLK_CHG: begin
          if (clk_s != sampled_r) begin
            clock_out_nxt = 1'b1;
            data_out_nxt  = 1'b0;
            phase_nxt     = hsbt_pkg::PH_RX_DATA_ON;
          end
        end
        hsbt_pkg::PH_RX_DATA_ON: begin
          if (dat_s) begin
            if (bits_r == 3'd0) begin
              phase_nxt = hsbt_pkg::PH_IDLE;
              done      = 1'b1;
            end else begin
              bits_nxt      = bits_r - 3'd1;
              clock_out_nxt = 1'b0;
              phase_nxt     = hsbt_pkg::PH_RX_DATA_OFF;
            end
          end
        end
        default: begin
          phase_nxt = hsbt_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= hsbt_pkg::PH_IDLE;
      bits_r      <= 3'd0;
      shift_r     <= 8'd0;
      sampled_r   <= 1'b0;
      receiving_r <= 1'b0;
      clock_out_r <= 1'b1;
      data_out_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        phase_r     <= phase_nxt;
        bits_r      <= bits_nxt;
        shift_r     <= shift_nxt;
        sampled_r   <= sampled_nxt;
        receiving_r <= receiving_nxt;
        clock_out_r <= clock_out_nxt;
        data_out_r  <= data_out_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      res_clock_r <= clock_out_nxt;
      res_data_r  <= data_out_nxt;
      res_busy_r  <= (phase_nxt != hsbt_pkg::PH_IDLE);
      res_done_r  <= done;
      res_rx_r    <= (done & receiving_nxt) ? shift_nxt : 8'd0;
      res_rej_r   <= rej;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_clock_drive = res_clock_r;
  assign out_data_drive  = res_data_r;
  assign out_busy_res    = res_busy_r;
  assign out_done_res    = res_done_r;
  assign out_rx_byte     = res_rx_r;
  assign out_rejected    = res_rej_r;

endmodule
`default_nettype wire

// ===== sv/two_wire_handshake_byte_transfer.sv =====
// top level of the two-line handshaked byte transfer host
// Each accepted item (a send or receive command, or a tick with sampled
// CLOCK and DATA levels) gives exactly one result: the host drive levels,
// busy, done, the received byte and a reject flag. The block takes one item
// every clock while the queue has room: the front end classifies it into a
// two-entry queue and the back end state machine retires one queued item per
// clock into an output register while the output side is ready; a result
// passes through a queue entry and the output register. A stalled output
// backs up the queue, and in_ready drops only once both entries are held.
`timescale 1ns / 1ps
`default_nettype none
module two_wire_handshake_byte_transfer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_op,
  input  wire logic [7:0] in_tx_byte,
  input  wire logic       in_clock_seen,
  input  wire logic       in_data_seen,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_clock_drive,
  output logic            out_data_drive,
  output logic            out_busy_res,
  output logic            out_done_res,
  output logic [7:0]      out_rx_byte,
  output logic            out_rejected
);

  hsbt_pkg::item_t push_item;
  hsbt_pkg::item_t q_item;
  logic            push;
  logic            full;
  logic            pop;
  logic            q_valid;

  hsbt_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_tx_byte    (in_tx_byte),
    .in_clock_seen (in_clock_seen),
    .in_data_seen  (in_data_seen),
    .q_full        (full),
    .q_push        (push),
    .q_item        (push_item)
  );

  hsbt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  hsbt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_clock_drive (out_clock_drive),
    .out_data_drive  (out_data_drive),
    .out_busy_res    (out_busy_res),
    .out_done_res    (out_done_res),
    .out_rx_byte     (out_rx_byte),
    .out_rejected    (out_rejected)
  );

endmodule
`default_nettype wire

// ===== sv/hsbt_checker.sv =====
// port-level checks for the byte transfer host and its bind
`timescale 1ns / 1ps
`default_nettype none
module hsbt_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_clock_drive,
  input wire logic       out_data_drive,
  input wire logic       out_busy_res,
  input wire logic       out_done_res,
  input wire logic [7:0] out_rx_byte,
  input wire logic       out_rejected
);

  // stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rx_byte)
      && $stable(out_done_res) && $stable(out_busy_res))
    else $error("stalled result item changed");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res && !out_rejected)
    else $error("done item while busy or rejected");

  a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_clock_drive && !out_data_drive)
    else $error("idle host not holding clock asserted and data released");

  a_rx_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rx_byte != 8'd0) |-> out_done_res)
    else $error("received byte shown without done");

endmodule

bind two_wire_handshake_byte_transfer hsbt_checker u_hsbt_checker (.*);
`default_nettype wire
